// ===== rtl/core/mcr_pkg.sv =====
`timescale 1ns / 1ps

package mcr_pkg;

  // Bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register offsets within the window
  localparam logic [7:0] ADDR_D    = 8'h52;
  localparam logic [7:0] ADDR_C    = 8'h53;
  localparam logic [7:0] ADDR_B    = 8'h54;
  localparam logic [7:0] ADDR_A    = 8'h55;
  localparam logic [7:0] ADDR_P    = 8'h56;
  localparam logic [7:0] ADDR_N    = 8'h57;
  localparam logic [7:0] ADDR_H    = 8'h60;
  localparam logic [7:0] ADDR_G    = 8'h61;
  localparam logic [7:0] ADDR_F    = 8'h62;
  localparam logic [7:0] ADDR_E    = 8'h63;
  localparam logic [7:0] ADDR_M    = 8'h6C;
  localparam logic [7:0] ADDR_L    = 8'h6D;
  localparam logic [7:0] ADDR_K    = 8'h6E;
  localparam logic [7:0] ADDR_J    = 8'h6F;
  localparam logic [7:0] ADDR_HREV = 8'h88;
  localparam logic [7:0] ADDR_SREV = 8'h89;
  localparam logic [7:0] ADDR_CTRL = 8'h92;

  // Control register bits and fixed read values
  localparam int unsigned CTRL_SIGN_BIT = 7;
  localparam int unsigned CTRL_ACC_BIT  = 6;
  localparam logic [7:0]  CTRL_SIGN     = 8'h80;
  localparam logic [7:0]  REV_VALUE     = 8'h01;

  // Divider: one quotient bit per cycle over the 32-bit dividend
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } mcr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // transaction accepted this cycle
    logic mul_commit;  // write product (plus accumulate) into EFGH
    logic div_step;    // one restoring division step
    logic div_last;    // final step: write quotient and remainder
  } mcr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_mul;   // offered transaction is a write to A
    logic start_div;   // offered transaction is a write to E
    logic np_zero;     // divisor is zero
  } mcr_sts_t;

endpackage

// ===== rtl/core/math_coprocessor_registers.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | op_i, reg_addr_i[7:0], wdata_i[7:0]
// out     | output    | out_valid_o/out_ready_i | rdata_o[7:0]
//
// Reads and plain writes: result registered, valid in the cycle after acceptance,
// next transaction taken the same cycle the result is taken. A write to A holds
// input off while EFGH takes the product, plain or accumulated. A write to E holds
// it off to divide, one quotient bit per cycle; a zero NP sets AB, CD to all ones.
// Reset is asynchronous, active low, and clears the coprocessor registers to zero.
// A stalled result holds the input side off until it is taken.

module math_coprocessor_registers
  import mcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] wdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] rdata_o
);

  mcr_cmd_t cmd;
  mcr_sts_t sts;

  // Sequencer
  mcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Registers, multiplier and divider
  mcr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_i),
    .reg_addr_i (reg_addr_i),
    .wdata_i    (wdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rdata_o    (rdata_o)
  );

endmodule

// ===== rtl/core/mcr_ctrl.sv =====
`timescale 1ns / 1ps

module mcr_ctrl
  import mcr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  mcr_sts_t sts_i,
  output mcr_cmd_t cmd_o
);

  mcr_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  // Take a transaction only when idle and the output slot frees up
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.start_mul) begin
          state_d = ST_MUL;
        end else if (accept && sts_i.start_div && !sts_i.np_zero) begin
          state_d = ST_DIV;
        end
      end
      ST_MUL: state_d = ST_IDLE;
      ST_DIV: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs to the datapath
  always_comb begin
    cmd_o = '0;
    cmd_o.load = accept;
    unique case (state_q)
      ST_IDLE: ;
      ST_MUL:  cmd_o.mul_commit = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = (cnt_q == CNT_LAST);
      end
      default: ;
    endcase
  end

  // Step counter and result valid
  always_comb begin
    cnt_d = (state_q == ST_DIV) ? cnt_q + 1'b1 : '0;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE))
    else $error("ready raised outside idle");

  a_mul_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_IDLE))
    else $error("multiply commit took more than one cycle");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && (cnt_q != CNT_LAST)) |=> (state_q == ST_DIV))
    else $error("division left early");

  a_idle_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("step counter not cleared in idle");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted transaction produced no result");

endmodule

// ===== rtl/core/mcr_dp.sv =====
`timescale 1ns / 1ps

module mcr_dp
  import mcr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] wdata_i,
  input  mcr_cmd_t   cmd_i,
  output mcr_sts_t   sts_o,
  output logic [7:0] rdata_o
);

  // Architectural registers
  logic [15:0] ab_q, cd_q, np_q;
  logic [31:0] efgh_q, jklm_q;
  logic        sign_q, acc_q;

  // Working registers
  logic [31:0] prod_q;
  logic [31:0] quot_q, quot_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  rdata_q, rdata_d;

  logic        is_write;
  logic [15:0] ab_new;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_full;
  logic [16:0] trial;
  logic [17:0] diff;

  assign is_write        = (op_i == OP_WRITE);
  assign sts_o.start_mul = is_write && (reg_addr_i == ADDR_A);
  assign sts_o.start_div = is_write && (reg_addr_i == ADDR_E);
  assign sts_o.np_zero   = (np_q == '0);

  // Multiplier sees AB with the new high byte
  assign ab_new   = {wdata_i, ab_q[7:0]};
  assign mul_a    = {sign_q & ab_new[15], ab_new};
  assign mul_b    = {sign_q & cd_q[15], cd_q};
  assign mul_full = mul_a * mul_b;

  // Restoring division step
  always_comb begin
    trial = {rem_q, quot_q[31]};
    diff  = {1'b0, trial} - {2'b00, np_q};
    if (!diff[17]) begin
      rem_d  = diff[15:0];
      quot_d = {quot_q[30:0], 1'b1};
    end else begin
      rem_d  = trial[15:0];
      quot_d = {quot_q[30:0], 1'b0};
    end
  end

  // Read mux; writes return zero
  always_comb begin
    rdata_d = '0;
    if (!is_write) begin
      unique case (reg_addr_i) inside
        ADDR_D:               rdata_d = cd_q[7:0];
        ADDR_C:               rdata_d = cd_q[15:8];
        ADDR_B:               rdata_d = ab_q[7:0];
        ADDR_A:               rdata_d = ab_q[15:8];
        ADDR_P:               rdata_d = np_q[7:0];
        ADDR_N:               rdata_d = np_q[15:8];
        ADDR_H:               rdata_d = efgh_q[7:0];
        ADDR_G:               rdata_d = efgh_q[15:8];
        ADDR_F:               rdata_d = efgh_q[23:16];
        ADDR_E:               rdata_d = efgh_q[31:24];
        ADDR_M:               rdata_d = jklm_q[7:0];
        ADDR_L:               rdata_d = jklm_q[15:8];
        ADDR_K:               rdata_d = jklm_q[23:16];
        ADDR_J:               rdata_d = jklm_q[31:24];
        ADDR_HREV, ADDR_SREV: rdata_d = REV_VALUE;
        ADDR_CTRL:            rdata_d = sign_q ? CTRL_SIGN : 8'h00;
        default:              rdata_d = '0;
      endcase
    end
  end

  // Register file updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_q   <= '0;
      cd_q   <= '0;
      np_q   <= '0;
      efgh_q <= '0;
      jklm_q <= '0;
      sign_q <= 1'b0;
      acc_q  <= 1'b0;
    end else begin
      if (cmd_i.load && is_write) begin
        unique case (reg_addr_i)
          ADDR_D: cd_q[7:0]      <= wdata_i;
          ADDR_C: cd_q[15:8]     <= wdata_i;
          ADDR_B: ab_q[7:0]      <= wdata_i;
          ADDR_A: ab_q[15:8]     <= wdata_i;
          ADDR_P: np_q[7:0]      <= wdata_i;
          ADDR_N: np_q[15:8]     <= wdata_i;
          ADDR_H: efgh_q[7:0]    <= wdata_i;
          ADDR_G: efgh_q[15:8]   <= wdata_i;
          ADDR_F: efgh_q[23:16]  <= wdata_i;
          ADDR_E: begin
            efgh_q[31:24] <= wdata_i;
            // Zero divisor resolves at once
            if (np_q == '0) begin
              ab_q <= '1;
              cd_q <= '1;
            end
          end
          ADDR_M: jklm_q[7:0]    <= wdata_i;
          ADDR_L: jklm_q[15:8]   <= wdata_i;
          ADDR_K: jklm_q[23:16]  <= wdata_i;
          ADDR_J: jklm_q[31:24]  <= wdata_i;
          ADDR_CTRL: begin
            sign_q <= wdata_i[CTRL_SIGN_BIT];
            acc_q  <= wdata_i[CTRL_ACC_BIT];
          end
          default: ;
        endcase
      end
      if (cmd_i.mul_commit) begin
        efgh_q <= acc_q ? prod_q + efgh_q : prod_q;
      end
      if (cmd_i.div_last) begin
        ab_q <= quot_d[15:0];
        cd_q <= rem_d;
      end
    end
  end

  // Product stage, divider shift registers and read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q <= rdata_d;
    end
    if (cmd_i.load && sts_o.start_mul) begin
      prod_q <= mul_full[31:0];
    end
    if (cmd_i.load && sts_o.start_div) begin
      quot_q <= {wdata_i, efgh_q[23:0]};
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/coproc_checker.sv =====
`timescale 1ns / 1ps

module coproc_checker
  import mcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        op_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  rdata_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  // Shadow copy of the coprocessor registers
  logic [15:0] ab;
  logic [15:0] cd;
  logic [15:0] np;
  logic [31:0] efgh;
  logic [31:0] jklm;
  logic        sign_mode;
  logic        acc_mode;

  // Bytes the block owes us, oldest first (zero for writes)
  logic [7:0]  owed_bytes_q[$];
  logic [7:0]  want;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  // 16x16 multiply into EFGH, optionally accumulating with 32-bit wrap
  task automatic run_multiply();
    logic signed [31:0] sprod;
    logic [31:0]        uprod;
    logic [31:0]        prod;
    sprod = $signed({{16{ab[15]}}, ab}) * $signed({{16{cd[15]}}, cd});
    uprod = {16'd0, ab} * {16'd0, cd};
    prod  = sign_mode ? sprod : uprod;
    efgh  = acc_mode ? prod + efgh : prod;
  endtask

  // EFGH / NP: truncated quotient to AB, remainder to CD; zero divisor gives all ones
  task automatic run_divide();
    logic [31:0] quo;
    logic [31:0] rem;
    if (np == 16'd0) begin
      ab = 16'hFFFF;
      cd = 16'hFFFF;
    end else begin
      quo = efgh / {16'd0, np};
      rem = efgh % {16'd0, np};
      ab  = quo[15:0];
      cd  = rem[15:0];
    end
  endtask

  function automatic logic [7:0] read_byte(input logic [7:0] addr);
    case (addr)
      ADDR_D:    return cd[7:0];
      ADDR_C:    return cd[15:8];
      ADDR_B:    return ab[7:0];
      ADDR_A:    return ab[15:8];
      ADDR_P:    return np[7:0];
      ADDR_N:    return np[15:8];
      ADDR_H:    return efgh[7:0];
      ADDR_G:    return efgh[15:8];
      ADDR_F:    return efgh[23:16];
      ADDR_E:    return efgh[31:24];
      ADDR_M:    return jklm[7:0];
      ADDR_L:    return jklm[15:8];
      ADDR_K:    return jklm[23:16];
      ADDR_J:    return jklm[31:24];
      ADDR_HREV: return REV_VALUE;
      ADDR_SREV: return REV_VALUE;
      ADDR_CTRL: return sign_mode ? CTRL_SIGN : 8'h00;
      default:   return 8'h00;
    endcase
  endfunction

  task automatic write_byte(input logic [7:0] addr, input logic [7:0] data);
    case (addr)
      ADDR_D: cd[7:0]   = data;
      ADDR_C: cd[15:8]  = data;
      ADDR_B: ab[7:0]   = data;
      ADDR_A: begin
        ab[15:8] = data;
        run_multiply();
      end
      ADDR_P: np[7:0]   = data;
      ADDR_N: np[15:8]  = data;
      ADDR_H: efgh[7:0]   = data;
      ADDR_G: efgh[15:8]  = data;
      ADDR_F: efgh[23:16] = data;
      ADDR_E: begin
        efgh[31:24] = data;
        run_divide();
      end
      ADDR_M: jklm[7:0]   = data;
      ADDR_L: jklm[15:8]  = data;
      ADDR_K: jklm[23:16] = data;
      ADDR_J: jklm[31:24] = data;
      ADDR_CTRL: begin
        sign_mode = data[CTRL_SIGN_BIT];
        acc_mode  = data[CTRL_ACC_BIT];
      end
      default: ;
    endcase
  endtask

  // Results are retired before new transactions are predicted: a result can
  // never belong to a transaction accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab        = 16'd0;
      cd        = 16'd0;
      np        = 16'd0;
      efgh      = 32'd0;
      jklm      = 32'd0;
      sign_mode = 1'b0;
      acc_mode  = 1'b0;
      owed_bytes_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_bytes_q.size() == 0) begin
          error_count_o = error_count_o + 1;
          if (error_count_o <= 10)
            $display("%0t: unexpected result rdata=%02h", $realtime, rdata_i);
        end else begin
          want = owed_bytes_q.pop_front();
          if (rdata_i !== want) begin
            error_count_o = error_count_o + 1;
            if (error_count_o <= 10)
              $display("%0t: rdata mismatch: expected %02h, got %02h",
                       $realtime, want, rdata_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (op_i == OP_WRITE) begin
          write_byte(reg_addr_i, wdata_i);
          owed_bytes_q.push_back(8'h00);
        end else begin
          owed_bytes_q.push_back(read_byte(reg_addr_i));
        end
      end
    end
    pending_o = owed_bytes_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mcr_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 217;
  localparam int unsigned STALL_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = OP_READ;
  logic [7:0] reg_addr_i  = 8'h00;
  logic [7:0] wdata_i     = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] rdata_o;

  int unsigned errors;
  int unsigned pending;

  // Flow-control knobs for the sender and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_req     = 1'b0;
  bit          stall_done    = 1'b0;
  int unsigned stall_left    = 0;

  int unsigned cycles   = 0;
  int unsigned sent     = 0;
  int unsigned n_reads  = 0;
  int unsigned n_writes = 0;
  int unsigned n_muls   = 0;
  int unsigned n_divs   = 0;

  always #1 clk_i = ~clk_i;

  math_coprocessor_registers uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .reg_addr_i  (reg_addr_i),
    .wdata_i     (wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rdata_o     (rdata_o)
  );

  coproc_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .reg_addr_i    (reg_addr_i),
    .wdata_i       (wdata_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rdata_i       (rdata_o),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_req && !stall_done) begin
      out_ready_i <= 1'b0;
      stall_left  <= STALL_CYCLES;
      stall_done  <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Byte with a bias toward the corners
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] mapped_addr();
    case ($urandom_range(16))
      0:       return ADDR_D;
      1:       return ADDR_C;
      2:       return ADDR_B;
      3:       return ADDR_A;
      4:       return ADDR_P;
      5:       return ADDR_N;
      6:       return ADDR_H;
      7:       return ADDR_G;
      8:       return ADDR_F;
      9:       return ADDR_E;
      10:      return ADDR_M;
      11:      return ADDR_L;
      12:      return ADDR_K;
      13:      return ADDR_J;
      14:      return ADDR_HREV;
      15:      return ADDR_SREV;
      default: return ADDR_CTRL;
    endcase
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic bus_access(input logic op, input logic [7:0] addr, input logic [7:0] data);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    reg_addr_i <= addr;
    wdata_i    <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (op == OP_WRITE) begin
      n_writes++;
      if (addr == ADDR_A) n_muls++;
      if (addr == ADDR_E) n_divs++;
    end else begin
      n_reads++;
    end
  endtask

  // Load operands, fire a multiply, read back part of EFGH
  task automatic multiply_burst();
    if ($urandom_range(3) == 0)
      bus_access(OP_WRITE, ADDR_CTRL, {2'($urandom_range(3)), 6'($urandom_range(63))});
    if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_D, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_C, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_B, rand_byte());
    bus_access(OP_WRITE, ADDR_A, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_READ, ADDR_E, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_READ, ADDR_F, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_READ, ADDR_G, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_READ, ADDR_H, rand_byte());
  endtask

  // Load dividend and divisor, fire a divide, read back quotient and remainder
  task automatic divide_burst();
    if ($urandom_range(6) == 0) begin
      bus_access(OP_WRITE, ADDR_P, 8'h00);
      bus_access(OP_WRITE, ADDR_N, 8'h00);
    end else begin
      if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_P, rand_byte());
      if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_N, rand_byte());
    end
    if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_H, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_G, rand_byte());
    if ($urandom_range(4) != 0) bus_access(OP_WRITE, ADDR_F, rand_byte());
    bus_access(OP_WRITE, ADDR_E, rand_byte());
    bus_access(OP_READ, ADDR_A, rand_byte());
    bus_access(OP_READ, ADDR_B, rand_byte());
    bus_access(OP_READ, ADDR_C, rand_byte());
    bus_access(OP_READ, ADDR_D, rand_byte());
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input bit with_stall);
    int unsigned stop_at;
    int unsigned pick;
    stop_at       = sent + ITEMS_PER_PHASE;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < stop_at) begin
      if (with_stall && sent + ITEMS_PER_PHASE > stop_at + 40) stall_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 35) begin
        multiply_burst();
      end else if (pick < 60) begin
        divide_burst();
      end else if (pick < 70) begin
        bus_access(OP_WRITE, ADDR_CTRL, rand_byte());
        bus_access(OP_READ, ADDR_CTRL, rand_byte());
      end else if ($urandom_range(1) == 0) begin
        bus_access(1'($urandom_range(1)), mapped_addr(), rand_byte());
      end else begin
        bus_access(1'($urandom_range(1)), 8'($urandom_range(255)), rand_byte());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fixed read values, unmapped reads
    bus_access(OP_READ, ADDR_HREV, 8'h00);
    bus_access(OP_READ, ADDR_SREV, 8'hFF);
    bus_access(OP_READ, ADDR_CTRL, 8'h00);
    bus_access(OP_READ, 8'h00, 8'h00);
    bus_access(OP_READ, 8'hFF, 8'hFF);
    // Unsigned max x max
    bus_access(OP_WRITE, ADDR_D, 8'hFF);
    bus_access(OP_WRITE, ADDR_C, 8'hFF);
    bus_access(OP_WRITE, ADDR_B, 8'hFF);
    bus_access(OP_WRITE, ADDR_A, 8'hFF);
    bus_access(OP_READ, ADDR_E, 8'h00);
    bus_access(OP_READ, ADDR_H, 8'h00);
    // Unsigned accumulate that wraps past 32 bits
    bus_access(OP_WRITE, ADDR_CTRL, 8'h40);
    bus_access(OP_WRITE, ADDR_A, 8'hFF);
    bus_access(OP_READ, ADDR_G, 8'h00);
    // Signed with accumulate
    bus_access(OP_WRITE, ADDR_CTRL, 8'hC0);
    bus_access(OP_READ, ADDR_CTRL, 8'h00);
    bus_access(OP_WRITE, ADDR_A, 8'h80);
    bus_access(OP_READ, ADDR_F, 8'h00);
    // Divide by a zero divisor
    bus_access(OP_WRITE, ADDR_E, 8'h12);
    bus_access(OP_READ, ADDR_A, 8'h00);
    bus_access(OP_READ, ADDR_D, 8'h00);
    // Divide by one: quotient wider than 16 bits
    bus_access(OP_WRITE, ADDR_P, 8'h01);
    bus_access(OP_WRITE, ADDR_E, 8'hFF);
    bus_access(OP_READ, ADDR_B, 8'h00);
    // Write to an unmapped offset
    bus_access(OP_WRITE, 8'hFF, 8'hFF);

    run_phase(31, 79, 1'b0);
    run_phase(79, 31, 1'b0);
    run_phase(0, 0, 1'b1);
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show any stray result
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d transactions: %0d reads, %0d writes, %0d multiplies, %0d divides",
             sent, n_reads, n_writes, n_muls, n_divs);
    $display("three flow-control phases and one %0d-cycle output hold-off, %0d errors",
             STALL_CYCLES, errors + pending);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
